### hw/rtl/hlt_pkg.sv
// Shared types and codes for the heartbeat liveness table.
`default_nettype none
package hlt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ADDR_W          = 16;
  localparam int ID_W            = 8;
  localparam int CNT_W           = 8;
  localparam int REP_W           = 3;
  localparam int MODE_W          = 2;

  localparam logic [CNT_W-1:0] RELOAD_RST = 8'd3;

  localparam logic [MODE_W-1:0] MODE_JOIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HB   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CMD  = 2'd3;

  localparam logic [REP_W-1:0] REP_JOINED  = 3'd0;
  localparam logic [REP_W-1:0] REP_REJOIN  = 3'd1;
  localparam logic [REP_W-1:0] REP_FULL    = 3'd2;
  localparam logic [REP_W-1:0] REP_HB_OK   = 3'd3;
  localparam logic [REP_W-1:0] REP_HB_UNK  = 3'd4;
  localparam logic [REP_W-1:0] REP_OFFLINE = 3'd5;
  localparam logic [REP_W-1:0] REP_SEND    = 3'd6;

  typedef struct packed {
    logic              valid;
    logic [REP_W-1:0]  report;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
    logic              led;
  } res_t;

  // Token that walks the cell chain, one cell per step.
  typedef struct packed {
    logic              active;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
    logic              led;
    logic              hit;
    logic              free_found;
    logic [ID_W-1:0]   hit_id;
    res_t              res;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
  } wr_t;

endpackage
`default_nettype wire

### hw/rtl/hlt_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface hlt_in_if;
  logic                      valid;
  logic                      ready;
  logic [hlt_pkg::MODE_W-1:0] mode;
  logic [hlt_pkg::ADDR_W-1:0] node_addr;
  logic [hlt_pkg::ID_W-1:0]   device_id;
  logic                      led_on;

  modport source (output valid, mode, node_addr, device_id, led_on, input ready);
  modport sink   (input valid, mode, node_addr, device_id, led_on, output ready);
endinterface

interface hlt_out_if;
  logic                      valid;
  logic                      ready;
  logic [hlt_pkg::REP_W-1:0]  report;
  logic [hlt_pkg::ADDR_W-1:0] entry_addr;
  logic [hlt_pkg::ID_W-1:0]   entry_id;
  logic                      led_state;
  logic                      last;

  modport source (output valid, report, entry_addr, entry_id, led_state, last, input ready);
  modport sink   (input valid, report, entry_addr, entry_id, led_state, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/hlt_cell.sv
// One table entry that processes the passing token and hands it to the next cell.
`default_nettype none
module hlt_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            en,
  input  hlt_pkg::tok_t                  tok_in,
  input  wire  [IDX_W-1:0]               free_in,
  output hlt_pkg::tok_t                  tok_out,
  output logic [IDX_W-1:0]               free_out,
  output hlt_pkg::res_t                  emit,
  input  hlt_pkg::wr_t                   wr,
  input  wire  [IDX_W-1:0]               wr_idx,
  input  wire  [hlt_pkg::CNT_W-1:0]      reload
);

  logic                       valid_r, valid_nxt;
  logic [hlt_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [hlt_pkg::ID_W-1:0]   ident_r, ident_nxt;
  logic [hlt_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [hlt_pkg::CNT_W-1:0]  count_dec;
  hlt_pkg::tok_t              tok_r, tok_nxt;
  logic [IDX_W-1:0]           free_r, free_nxt;
  hlt_pkg::res_t              new_res;

  assign count_dec = count_r - hlt_pkg::CNT_W'(1);

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    ident_nxt = ident_r;
    count_nxt = count_r;
    tok_nxt   = tok_in;
    free_nxt  = free_in;
    new_res   = '0;
    emit      = '0;
    if (en && tok_in.active) begin
      case (tok_in.mode)
        hlt_pkg::MODE_JOIN: begin
          if (valid_r) begin
            if (!tok_in.hit && ident_r == tok_in.id) begin
              tok_nxt.hit = 1'b1;
              addr_nxt    = tok_in.addr;
            end
          end else if (!tok_in.free_found) begin
            tok_nxt.free_found = 1'b1;
            free_nxt           = IDX_W'(IDX);
          end
        end
        hlt_pkg::MODE_HB: begin
          if (valid_r && !tok_in.hit && addr_r == tok_in.addr) begin
            tok_nxt.hit    = 1'b1;
            tok_nxt.hit_id = ident_r;
            count_nxt      = reload;
          end
        end
        hlt_pkg::MODE_TICK: begin
          if (valid_r) begin
            count_nxt = count_dec;
            if (count_dec == '0) begin
              valid_nxt      = 1'b0;
              new_res.valid  = 1'b1;
              new_res.report = hlt_pkg::REP_OFFLINE;
              new_res.addr   = addr_r;
              new_res.id     = ident_r;
            end
          end
        end
        default: begin
          if (valid_r && ident_r == tok_in.id) begin
            new_res.valid  = 1'b1;
            new_res.report = hlt_pkg::REP_SEND;
            new_res.addr   = addr_r;
            new_res.id     = ident_r;
            new_res.led    = tok_in.led;
          end
        end
      endcase
      // A new result pushes the one held in the token out, so the held one is
      // known not to be the last of its item.
      if (new_res.valid) begin
        emit        = tok_in.res;
        tok_nxt.res = new_res;
      end
    end
    if (wr.en && wr_idx == IDX_W'(IDX)) begin
      valid_nxt = 1'b1;
      addr_nxt  = wr.addr;
      ident_nxt = wr.id;
      count_nxt = wr.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (en) begin
        tok_r.active <= tok_nxt.active;
      end
    end
    addr_r  <= addr_nxt;
    ident_r <= ident_nxt;
    count_r <= count_nxt;
    if (en) begin
      tok_r.mode       <= tok_nxt.mode;
      tok_r.addr       <= tok_nxt.addr;
      tok_r.id         <= tok_nxt.id;
      tok_r.led        <= tok_nxt.led;
      tok_r.hit        <= tok_nxt.hit;
      tok_r.free_found <= tok_nxt.free_found;
      tok_r.hit_id     <= tok_nxt.hit_id;
      tok_r.res        <= tok_nxt.res;
      free_r           <= free_nxt;
    end
  end

  assign tok_out  = tok_r;
  assign free_out = free_r;

endmodule
`default_nettype wire

### hw/rtl/heartbeat_liveness_table.sv
// Top level of the heartbeat liveness table: cell chain, sequencing and output register.
//
// Input items arrive on in_ch (valid/ready). Each item is a join, a heartbeat,
// a tick or an led command. Results leave on out_ch, one per transfer, with
// last set on the final result of an item. Ticks and commands that remove or
// match nothing give no result at all.
// An accepted item becomes a token that walks the row of TABLE_DEPTH cells,
// one cell per cycle while out_ch does not stall, each cell holding one table
// entry. The token is held in tok0_r, then in the register of each cell in
// turn, and the final result is registered into the output register as the
// token leaves the last cell. busy is cleared then too, so the next item is
// accepted once that token has left; no new item is taken while a token walks.
// Results of ticks and commands are produced during the walk, at most one per
// cycle. When out_ch stalls with a result waiting, the walk freezes until that
// result is transferred. cfg_we writes the reload count used for new entries
// and heartbeats; write it only while the block is idle.
// Reset empties the table at once and sets the reload count to 3.
`default_nettype none
module heartbeat_liveness_table #(
  parameter int TABLE_DEPTH = hlt_pkg::TABLE_DEPTH_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  hlt_in_if.sink                    in_ch,
  hlt_out_if.source                 out_ch,
  input  wire                       cfg_we,
  input  wire  [hlt_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [hlt_pkg::CNT_W-1:0] reload_r;
  logic                      busy_r;
  hlt_pkg::tok_t             tok0_r;
  hlt_pkg::tok_t             tok   [TABLE_DEPTH+1];
  logic [IDX_W-1:0]          free  [TABLE_DEPTH+1];
  hlt_pkg::res_t             emits [TABLE_DEPTH];
  hlt_pkg::res_t             cell_em;
  hlt_pkg::res_t             final_res;
  hlt_pkg::tok_t             tok_end;
  hlt_pkg::wr_t              wr;
  logic [IDX_W-1:0]          wr_idx;
  logic                      en;
  logic                      in_fire;
  logic                      done;

  logic                      out_valid_r;
  logic                      out_last_r;
  hlt_pkg::res_t             out_res_r;

  assign en      = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && !busy_r;
  assign in_ch.ready = !busy_r;

  assign tok[0]  = tok0_r;
  assign free[0] = '0;
  assign tok_end = tok[TABLE_DEPTH];
  assign done    = en && tok_end.active;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    hlt_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .tok_in   (tok[g]),
      .free_in  (free[g]),
      .tok_out  (tok[g+1]),
      .free_out (free[g+1]),
      .emit     (emits[g]),
      .wr       (wr),
      .wr_idx   (wr_idx),
      .reload   (reload_r)
    );
  end

  // Only the cell holding the token can drive a result.
  always_comb begin
    cell_em = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_em = cell_em | emits[i];
    end
  end

  always_comb begin
    final_res = '0;
    wr        = '0;
    wr_idx    = free[TABLE_DEPTH];
    if (done) begin
      case (tok_end.mode)
        hlt_pkg::MODE_JOIN: begin
          final_res.valid = 1'b1;
          final_res.addr  = tok_end.addr;
          final_res.id    = tok_end.id;
          if (tok_end.hit) begin
            final_res.report = hlt_pkg::REP_REJOIN;
          end else if (tok_end.free_found) begin
            final_res.report = hlt_pkg::REP_JOINED;
            wr.en    = 1'b1;
            wr.addr  = tok_end.addr;
            wr.id    = tok_end.id;
            wr.count = reload_r;
          end else begin
            final_res.report = hlt_pkg::REP_FULL;
          end
        end
        hlt_pkg::MODE_HB: begin
          final_res.valid = 1'b1;
          final_res.addr  = tok_end.addr;
          if (tok_end.hit) begin
            final_res.report = hlt_pkg::REP_HB_OK;
            final_res.id     = tok_end.hit_id;
          end else begin
            final_res.report = hlt_pkg::REP_HB_UNK;
          end
        end
        default: begin
          final_res = tok_end.res;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r      <= hlt_pkg::RELOAD_RST;
      busy_r        <= 1'b0;
      tok0_r.active <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        reload_r <= cfg_wdata;
      end
      if (in_fire) begin
        busy_r        <= 1'b1;
        tok0_r.active <= 1'b1;
      end else begin
        if (en) begin
          tok0_r.active <= 1'b0;
        end
        if (done) begin
          busy_r <= 1'b0;
        end
      end
      if (en) begin
        out_valid_r <= cell_em.valid || final_res.valid;
      end
    end
    if (in_fire) begin
      tok0_r.mode       <= in_ch.mode;
      tok0_r.addr       <= in_ch.node_addr;
      tok0_r.id         <= in_ch.device_id;
      tok0_r.led        <= in_ch.led_on;
      tok0_r.hit        <= 1'b0;
      tok0_r.free_found <= 1'b0;
      tok0_r.hit_id     <= '0;
      tok0_r.res        <= '0;
    end
    if (en) begin
      if (cell_em.valid) begin
        out_res_r  <= cell_em;
        out_last_r <= 1'b0;
      end else begin
        out_res_r  <= final_res;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.report     = out_res_r.report;
  assign out_ch.entry_addr = out_res_r.addr;
  assign out_ch.entry_id   = out_res_r.id;
  assign out_ch.led_state  = out_res_r.led;
  assign out_ch.last       = out_last_r;

endmodule
`default_nettype wire

### test/tb.sv
// Testbench for the heartbeat liveness table: directed and random items checked against a table model.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = hlt_pkg::TABLE_DEPTH_DEF;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic [hlt_pkg::MODE_W-1:0] mode;
    logic [hlt_pkg::ADDR_W-1:0] addr;
    logic [hlt_pkg::ID_W-1:0]   id;
    logic                       led;
  } hb_item_t;

  typedef struct packed {
    logic [hlt_pkg::REP_W-1:0]  report;
    logic [hlt_pkg::ADDR_W-1:0] addr;
    logic [hlt_pkg::ID_W-1:0]   id;
    logic                       led;
    logic                       last;
  } report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hlt_pkg::CNT_W-1:0] cfg_wdata;

  hlt_in_if  in_ch ();
  hlt_out_if out_ch ();

  heartbeat_liveness_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Table model kept alongside the block.
  logic                       tbl_valid [DEPTH];
  logic [hlt_pkg::ADDR_W-1:0] tbl_addr  [DEPTH];
  logic [hlt_pkg::ID_W-1:0]   tbl_id    [DEPTH];
  logic [hlt_pkg::CNT_W-1:0]  tbl_count [DEPTH];
  logic [hlt_pkg::CNT_W-1:0]  tbl_reload;

  report_t pending_reports[$];
  int      mismatch_count;
  logic [hlt_pkg::ID_W-1:0] id_pool [POOL_SIZE];

  int burst_left;
  int hold_request;
  int hold_left;
  int stall_kind;
  int stall_left;
  int stall_phase;

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic report_t make_report(input logic [hlt_pkg::REP_W-1:0] rep,
                                          input logic [hlt_pkg::ADDR_W-1:0] addr,
                                          input logic [hlt_pkg::ID_W-1:0] id,
                                          input logic led);
    report_t r;
    r.report = rep;
    r.addr   = addr;
    r.id     = id;
    r.led    = led;
    r.last   = 1'b0;
    return r;
  endfunction

  // Applies one accepted item to the table model and queues the reports it causes.
  task automatic table_apply(input hb_item_t it);
    report_t made [DEPTH];
    int n;
    int hit;
    int freeslot;
    int i;
    n = 0;
    hit = -1;
    freeslot = -1;
    case (it.mode)
      hlt_pkg::MODE_JOIN: begin
        for (i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i]) begin
            if (hit < 0 && tbl_id[i] == it.id) hit = i;
          end else if (freeslot < 0) begin
            freeslot = i;
          end
        end
        if (hit >= 0) begin
          tbl_addr[hit] = it.addr;
          made[n++] = make_report(hlt_pkg::REP_REJOIN, it.addr, it.id, 1'b0);
        end else if (freeslot >= 0) begin
          tbl_valid[freeslot] = 1'b1;
          tbl_addr[freeslot]  = it.addr;
          tbl_id[freeslot]    = it.id;
          tbl_count[freeslot] = tbl_reload;
          made[n++] = make_report(hlt_pkg::REP_JOINED, it.addr, it.id, 1'b0);
        end else begin
          made[n++] = make_report(hlt_pkg::REP_FULL, it.addr, it.id, 1'b0);
        end
      end
      hlt_pkg::MODE_HB: begin
        for (i = 0; i < DEPTH; i++) begin
          if (hit < 0 && tbl_valid[i] && tbl_addr[i] == it.addr) hit = i;
        end
        if (hit >= 0) begin
          tbl_count[hit] = tbl_reload;
          made[n++] = make_report(hlt_pkg::REP_HB_OK, it.addr, tbl_id[hit], 1'b0);
        end else begin
          made[n++] = make_report(hlt_pkg::REP_HB_UNK, it.addr, '0, 1'b0);
        end
      end
      hlt_pkg::MODE_TICK: begin
        for (i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i]) begin
            // A counter at zero wraps around here and survives the tick.
            tbl_count[i] = tbl_count[i] - 1'b1;
            if (tbl_count[i] == '0) begin
              tbl_valid[i] = 1'b0;
              made[n++] = make_report(hlt_pkg::REP_OFFLINE, tbl_addr[i], tbl_id[i], 1'b0);
            end
          end
        end
      end
      default: begin
        for (i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i] && tbl_id[i] == it.id)
            made[n++] = make_report(hlt_pkg::REP_SEND, tbl_addr[i], tbl_id[i], it.led);
        end
      end
    endcase
    if (n > 0) made[n-1].last = 1'b1;
    for (i = 0; i < n; i++) pending_reports.push_back(made[i]);
  endtask

  task automatic note_mismatch(input string what, input report_t want, input report_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"mismatch, %s: expected rep=%0d addr=%h id=%h led=%b last=%b,",
                " got rep=%0d addr=%h id=%h led=%b last=%b"},
               what, want.report, want.addr, want.id, want.led, want.last,
               got.report, got.addr, got.id, got.led, got.last);
  endtask

  always @(posedge clk) begin : check_reports
    report_t got;
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.report = out_ch.report;
      got.addr   = out_ch.entry_addr;
      got.id     = out_ch.entry_id;
      got.led    = out_ch.led_state;
      got.last   = out_ch.last;
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.report !== want.report || got.addr !== want.addr || got.id !== want.id ||
            got.led !== want.led || got.last !== want.last)
          note_mismatch("wrong result", want, got);
      end
    end
  end

  // Receiver: a long hold-off on request, otherwise a changing stall pattern.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_phase++;
      case (stall_kind)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 3) != 0);
        2: out_ch.ready = (stall_phase % 5 != 0);
        default: out_ch.ready = 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Offers one item from a falling edge and returns at the falling edge after its transfer.
  task automatic send_item(input logic [hlt_pkg::MODE_W-1:0] mode,
                           input logic [hlt_pkg::ADDR_W-1:0] addr,
                           input logic [hlt_pkg::ID_W-1:0] id, input logic led);
    hb_item_t it;
    int gap;
    it.mode = mode;
    it.addr = addr;
    it.id   = id;
    it.led  = led;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid     = 1'b1;
    in_ch.mode      = it.mode;
    in_ch.node_addr = it.addr;
    in_ch.device_id = it.id;
    in_ch.led_on    = it.led;
    do @(posedge clk); while (!in_ch.ready);
    table_apply(it);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    // Ticks and commands may still be walking the table with nothing to report.
    repeat (DEPTH + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reload(input logic [hlt_pkg::CNT_W-1:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tbl_reload = value;
  endtask

  function automatic int pick_live_slot();
    int live;
    int k;
    int i;
    live = 0;
    for (i = 0; i < DEPTH; i++) if (tbl_valid[i]) live++;
    if (live == 0) return -1;
    k = $urandom_range(0, live - 1);
    for (i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i]) begin
        if (k == 0) return i;
        k--;
      end
    end
    return -1;
  endfunction

  task automatic clear_table();
    while (pick_live_slot() >= 0) send_item(hlt_pkg::MODE_TICK, '0, '0, 1'b0);
  endtask

  task automatic test_empty_table();
    send_item(hlt_pkg::MODE_TICK, 16'h0000, 8'h00, 1'b0);
    send_item(hlt_pkg::MODE_CMD,  16'hFFFF, 8'h00, 1'b1);
    send_item(hlt_pkg::MODE_HB,   16'hFFFF, 8'hFF, 1'b1);
    send_item(hlt_pkg::MODE_HB,   16'h0000, 8'h00, 1'b0);
  endtask

  task automatic test_join_heartbeat();
    send_item(hlt_pkg::MODE_JOIN, 16'h0000, 8'h00, 1'b0);
    send_item(hlt_pkg::MODE_JOIN, 16'hFFFF, 8'hFF, 1'b1);
    send_item(hlt_pkg::MODE_JOIN, 16'h1234, 8'h5A, 1'b0);
    // Same address as the entry above, so a heartbeat must pick the lower slot.
    send_item(hlt_pkg::MODE_JOIN, 16'h1234, 8'hA5, 1'b0);
    send_item(hlt_pkg::MODE_JOIN, 16'hABCD, 8'hFF, 1'b0);
    send_item(hlt_pkg::MODE_HB,   16'hABCD, 8'h00, 1'b0);
    send_item(hlt_pkg::MODE_HB,   16'h1234, 8'h00, 1'b1);
    send_item(hlt_pkg::MODE_CMD,  16'h0000, 8'hFF, 1'b1);
    send_item(hlt_pkg::MODE_CMD,  16'hFFFF, 8'h00, 1'b0);
    send_item(hlt_pkg::MODE_CMD,  16'h5555, 8'h77, 1'b1);
  endtask

  task automatic test_aging();
    send_item(hlt_pkg::MODE_TICK, 16'h0000, 8'h00, 1'b0);
    send_item(hlt_pkg::MODE_HB,   16'hABCD, 8'h00, 1'b0);
    send_item(hlt_pkg::MODE_TICK, 16'hFFFF, 8'hFF, 1'b1);
    send_item(hlt_pkg::MODE_TICK, 16'h0000, 8'h00, 1'b0);
    send_item(hlt_pkg::MODE_JOIN, 16'h4242, 8'h42, 1'b0);
  endtask

  task automatic test_zero_reload();
    write_reload(8'd0);
    send_item(hlt_pkg::MODE_JOIN, 16'h0F0F, 8'h3C, 1'b0);
    send_item(hlt_pkg::MODE_TICK, 16'h0000, 8'h00, 1'b0);
    write_reload(8'd255);
    send_item(hlt_pkg::MODE_HB, 16'h0F0F, 8'h00, 1'b0);
    write_reload(8'd1);
    send_item(hlt_pkg::MODE_HB, 16'h0F0F, 8'h00, 1'b0);
    send_item(hlt_pkg::MODE_TICK, 16'h0000, 8'h00, 1'b0);
  endtask

  task automatic test_table_full();
    logic [hlt_pkg::ID_W-1:0] first_id;
    int i;
    write_reload(8'd1);
    clear_table();
    for (i = 0; i < DEPTH; i++)
      send_item(hlt_pkg::MODE_JOIN, 16'($urandom),
                8'((i % 16) * 16 + $urandom_range(0, 15)), 1'($urandom));
    first_id = tbl_id[0];
    send_item(hlt_pkg::MODE_JOIN, 16'($urandom), first_id ^ 8'h01, 1'b0);
    send_item(hlt_pkg::MODE_JOIN, 16'($urandom), tbl_id[3], 1'b1);
    send_item(hlt_pkg::MODE_CMD,  16'($urandom), tbl_id[5], 1'b1);
    // Every entry holds one tick of life, so this tick reports them all.
    send_item(hlt_pkg::MODE_TICK, 16'($urandom), 8'($urandom), 1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    wait_idle();
    hold_request = 400;
    for (i = 0; i < 6; i++)
      send_item((i % 2 == 0) ? hlt_pkg::MODE_JOIN : hlt_pkg::MODE_HB, 16'($urandom),
                id_pool[$urandom_range(0, POOL_SIZE - 1)], 1'($urandom));
    wait_idle();
  endtask

  function automatic hb_item_t random_item();
    hb_item_t it;
    int r;
    int slot;
    r = $urandom_range(0, 99);
    slot = pick_live_slot();
    it.mode = hlt_pkg::MODE_JOIN;
    it.addr = 16'($urandom);
    it.id   = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    it.led  = 1'($urandom);
    if (r < 8) begin
      it.mode = 2'($urandom_range(0, 3));
      it.id   = 8'($urandom);
    end else if (r < 40) begin
      it.mode = hlt_pkg::MODE_JOIN;
      if (slot >= 0 && $urandom_range(0, 4) == 0) it.addr = tbl_addr[slot];
    end else if (r < 68) begin
      it.mode = hlt_pkg::MODE_HB;
      if (slot >= 0 && $urandom_range(0, 4) != 0) it.addr = tbl_addr[slot];
    end else if (r < 85) begin
      it.mode = hlt_pkg::MODE_TICK;
    end else begin
      it.mode = hlt_pkg::MODE_CMD;
      if (slot >= 0 && $urandom_range(0, 9) < 7) it.id = tbl_id[slot];
    end
    return it;
  endfunction

  task automatic test_random(input logic [hlt_pkg::CNT_W-1:0] reload, input int count);
    hb_item_t it;
    int i;
    write_reload(reload);
    for (i = 0; i < POOL_SIZE; i++) id_pool[i] = 8'($urandom);
    id_pool[0] = 8'h00;
    id_pool[1] = 8'hFF;
    for (i = 0; i < count; i++) begin
      it = random_item();
      send_item(it.mode, it.addr, it.id, it.led);
    end
  endtask

  initial begin : run
    int i;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = hlt_pkg::MODE_JOIN;
    in_ch.node_addr = '0;
    in_ch.device_id = '0;
    in_ch.led_on = 1'b0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    burst_left = 0;
    hold_request = 0;
    hold_left = 0;
    stall_kind = 0;
    stall_left = 0;
    stall_phase = 0;
    tbl_reload = hlt_pkg::RELOAD_RST;
    for (i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i]  = '0;
      tbl_id[i]    = '0;
      tbl_count[i] = '0;
    end
    for (i = 0; i < POOL_SIZE; i++) id_pool[i] = 8'($urandom);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_table();
    test_join_heartbeat();
    test_aging();
    test_zero_reload();
    test_table_full();
    test_backpressure();
    test_random(8'd3, 54);
    test_random(8'd1, 54);
    test_random(8'd255, 54);
    test_random(8'($urandom_range(2, 9)), 54);
    test_random(8'($urandom_range(1, 255)), 54);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hw/rtl/hlt_pkg.sv
hw/rtl/hlt_if.sv
hw/rtl/hlt_cell.sv
hw/rtl/heartbeat_liveness_table.sv
test/tb.sv
